### hw/rtl/htw_pkg.sv
// htw_pkg: request codes, result status codes and fixed field widths of the timing wheel
`default_nettype none
package htw_pkg;

    localparam int TMO_W = 32;
    localparam int SI_W  = 16;
    localparam int ID_W  = 5;
    localparam int ST_W  = 3;
    localparam int ROT_W = 31;
    localparam int REQ_W = 2;

    // wheel size, a power of two so ticks split into slot and rotation by bit position
    localparam int SLOTS = 64;

    localparam logic [REQ_W-1:0] REQ_ADD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEL  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

    localparam logic [ST_W-1:0] ST_ADDED = 3'd0;
    localparam logic [ST_W-1:0] ST_NEG   = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 3'd2;
    localparam logic [ST_W-1:0] ST_DEL   = 3'd3;
    localparam logic [ST_W-1:0] ST_IGN   = 3'd4;
    localparam logic [ST_W-1:0] ST_EXP   = 3'd5;
    localparam logic [ST_W-1:0] ST_DONE  = 3'd6;

    localparam logic [ID_W-1:0] DIV_LAST_STEP = 5'd31;

endpackage
`default_nettype wire

### hw/rtl/hashed_timing_wheel.sv
// hashed_timing_wheel: timer pool on a hashed wheel with a bit-serial divider
// transfer to result: delete and negative timeout directly, pool full after a full scan,
// add after free-entry scan, 32 divider steps for timeout / slot_interval and write;
// tick: one pool entry per cycle unless an expiry meets a stalled output, then closing result;
// one item at a time, next transfer in the cycle after the last result is registered; sync
// reset clears valid bits, output valid, current slot, interval to 1
`default_nettype none
module hashed_timing_wheel
    import htw_pkg::*;
#(
    parameter int TIMERS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_slot_interval_we,
    input  wire logic [SI_W-1:0]   i_slot_interval,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [REQ_W-1:0]  i_req_type,
    input  wire logic [TMO_W-1:0]  i_timeout,
    input  wire logic [ID_W-1:0]   i_timer_id,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [ID_W-1:0]        o_timer_id_out,
    output logic [ST_W-1:0]        o_status,
    output logic                   o_last
);

    localparam int SW = $clog2(SLOTS);
    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CW = $clog2(TIMERS + 1);
    localparam int MW = SW + ROT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_DIV_TMO,
        S_ADD_WR,
        S_TICK,
        S_RESP
    } t_state;

    t_state               r_state;
    logic [SI_W-1:0]      r_slot_interval;
    logic [TIMERS-1:0]    r_entry_valid;
    logic [SW-1:0]        r_cur_slot;
    logic [CW-1:0]        r_idx;
    logic [TMO_W-2:0]     r_tmo;
    logic [TMO_W-1:0]     r_quo;
    logic [SI_W-1:0]      r_rem;
    logic [SI_W-1:0]      r_dvs;
    logic [ID_W-1:0]      r_cnt;
    logic [ID_W-1:0]      r_res_id;
    logic [ST_W-1:0]      r_res_st;
    logic                 r_o_valid;
    logic [ID_W-1:0]      r_o_id;
    logic [ST_W-1:0]      r_o_st;
    logic                 r_o_last;

    logic [MW-1:0]        r_mem [TIMERS];
    logic [MW-1:0]        r_rd;

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_emit;
    logic [SI_W:0]        w_sh;
    logic                 w_ge;
    logic [SI_W:0]        w_sub;
    logic [SI_W-1:0]      w_rem_nx;
    logic [TMO_W-1:0]     w_quo_nx;
    logic [SI_W-1:0]      w_si_eff;
    logic [SW-1:0]        w_new_slot;
    logic [SW-1:0]        w_rd_slot;
    logic [ROT_W-1:0]     w_rd_rot;
    logic                 w_hit;
    logic                 w_expire;
    logic                 w_tick_adv;
    logic [IW-1:0]        w_idx;
    logic [CW-1:0]        w_idx_inc;
    logic [IW-1:0]        w_raddr;
    logic                 w_we;
    logic [MW-1:0]        w_wdata;
    logic [IW-1:0]        w_del_idx;
    logic                 w_del_ok;
    logic [SW-1:0]        w_cur_inc;

    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_o_valid || !i_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_timer_id_out = r_o_id;
    assign o_status       = r_o_st;
    assign o_last         = r_o_last;

    // one restoring division step
    assign w_sh     = {r_rem, r_quo[TMO_W-1]};
    assign w_ge     = (w_sh >= {1'b0, r_dvs});
    assign w_sub    = w_sh - {1'b0, r_dvs};
    assign w_rem_nx = w_ge ? w_sub[SI_W-1:0] : w_sh[SI_W-1:0];
    assign w_quo_nx = {r_quo[TMO_W-2:0], w_ge};

    assign w_si_eff   = (r_slot_interval == '0) ? SI_W'(1) : r_slot_interval;
    assign w_new_slot = r_cur_slot + r_quo[SW-1:0];
    assign w_cur_inc  = (r_cur_slot == SW'(SLOTS - 1)) ? '0 : r_cur_slot + 1'b1;

    assign w_rd_slot  = r_rd[MW-1:ROT_W];
    assign w_rd_rot   = r_rd[ROT_W-1:0];
    assign w_idx      = r_idx[IW-1:0];
    assign w_idx_inc  = r_idx + 1'b1;
    assign w_hit      = r_entry_valid[w_idx] && (w_rd_slot == r_cur_slot);
    assign w_expire   = (r_state == S_TICK) && w_hit && (w_rd_rot == '0);
    assign w_tick_adv = !(w_expire && !w_out_free);
    assign w_emit     = w_out_free && (w_expire || (r_state == S_RESP));

    assign w_raddr = (r_state != S_TICK) ? '0 :
                     (w_tick_adv ? w_idx_inc[IW-1:0] : w_idx);

    assign w_we    = (r_state == S_ADD_WR) ||
                     ((r_state == S_TICK) && w_hit && (w_rd_rot != '0));
    assign w_wdata = (r_state == S_ADD_WR) ?
                     {w_new_slot, ROT_W'(r_quo[TMO_W-1:SW])} :
                     {w_rd_slot, w_rd_rot - 1'b1};

    assign w_del_idx = IW'(i_timer_id);
    assign w_del_ok  = ({27'd0, i_timer_id} < 32'(TIMERS)) && r_entry_valid[w_del_idx];

    // entry memory: slot and rotation per pool entry
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_idx] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_slot_interval <= SI_W'(1);
            r_entry_valid   <= '0;
            r_cur_slot      <= '0;
            r_idx           <= '0;
            r_o_valid       <= 1'b0;
        end else begin
            if (i_slot_interval_we) begin
                r_slot_interval <= i_slot_interval;
            end
            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (w_accept) begin
                        r_tmo <= i_timeout[TMO_W-2:0];
                        priority if (i_req_type == REQ_ADD) begin
                            if (i_timeout[TMO_W-1]) begin
                                r_res_id <= '0;
                                r_res_st <= ST_NEG;
                                r_state  <= S_RESP;
                            end else begin
                                r_state <= S_ADD_SCAN;
                            end
                        end else if (i_req_type == REQ_DEL) begin
                            r_res_id <= i_timer_id;
                            if (w_del_ok) begin
                                r_entry_valid[w_del_idx] <= 1'b0;
                                r_res_st <= ST_DEL;
                            end else begin
                                r_res_st <= ST_IGN;
                            end
                            r_state <= S_RESP;
                        end else if (i_req_type == REQ_TICK) begin
                            r_state <= S_TICK;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_ADD_SCAN: begin
                    if (r_idx == CW'(TIMERS)) begin
                        r_res_id <= '0;
                        r_res_st <= ST_FULL;
                        r_state  <= S_RESP;
                    end else if (!r_entry_valid[w_idx]) begin
                        r_quo   <= {1'b0, r_tmo};
                        r_rem   <= '0;
                        r_dvs   <= w_si_eff;
                        r_cnt   <= DIV_LAST_STEP;
                        r_state <= S_DIV_TMO;
                    end else begin
                        r_idx <= w_idx_inc;
                    end
                end
                S_DIV_TMO: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        // ticks, at least one
                        r_quo   <= (w_quo_nx == '0) ? TMO_W'(1) : w_quo_nx;
                        r_state <= S_ADD_WR;
                    end else begin
                        r_quo <= w_quo_nx;
                        r_rem <= w_rem_nx;
                    end
                end
                S_ADD_WR: begin
                    r_entry_valid[w_idx] <= 1'b1;
                    r_res_id <= ID_W'(r_idx);
                    r_res_st <= ST_ADDED;
                    r_state  <= S_RESP;
                end
                S_TICK: begin
                    if (w_expire && w_out_free) begin
                        r_entry_valid[w_idx] <= 1'b0;
                        r_o_id    <= ID_W'(r_idx);
                        r_o_st    <= ST_EXP;
                        r_o_last  <= 1'b0;
                    end
                    if (w_tick_adv) begin
                        r_idx <= w_idx_inc;
                        if (r_idx == CW'(TIMERS - 1)) begin
                            r_cur_slot <= w_cur_inc;
                            r_res_id   <= '0;
                            r_res_st   <= ST_DONE;
                            r_state    <= S_RESP;
                        end
                    end
                end
                S_RESP: begin
                    if (w_out_free) begin
                        r_o_id    <= r_res_id;
                        r_o_st    <= r_res_st;
                        r_o_last  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_not_last_is_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_status == ST_EXP))
        else $error("non-final result is not an expiry");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_TMO) |-> (r_dvs != '0))
        else $error("divider runs with a zero divisor");

    a_tick_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK) |-> (r_idx < CW'(TIMERS)))
        else $error("tick scan index out of range");

    a_expiry_frees_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_expire && w_out_free) |=> !r_entry_valid[$past(w_idx)])
        else $error("expired entry still valid");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule
`default_nettype wire
